/* src/btlv_pkg.sv */
// ----------------------------------------------------------------------------
// BER-TLV stream parser package
// Shared constants, payload structs and control structs for the parser core
// and its end-position stack.
// ----------------------------------------------------------------------------
package btlv_pkg;

  // Structural limits of the parser.
  localparam int MAX_DEPTH    = 8;
  localparam int TAG_BYTES    = 4;
  localparam int LENGTH_BYTES = 2;

  // Derived widths.
  localparam int POS_W   = 24;
  localparam int LEVEL_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CLOSE_W = $clog2(MAX_DEPTH + 2);
  localparam int TCNT_W  = $clog2(TAG_BYTES + 1);
  localparam int LEFT_W  = $clog2(LENGTH_BYTES + 1);

  // Byte role codes.
  localparam logic [1:0] ROLE_TAG     = 2'd0;
  localparam logic [1:0] ROLE_LENGTH  = 2'd1;
  localparam logic [1:0] ROLE_VALUE   = 2'd2;
  localparam logic [1:0] ROLE_DISCARD = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TAG_LONG  = 3'd1;
  localparam logic [2:0] ERR_LEN_FORM  = 3'd2;
  localparam logic [2:0] ERR_OVERRUN   = 3'd3;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  // Parse phase, one-hot.
  typedef enum logic [4:0] {
    PH_TAG_FIRST = 5'b00001,
    PH_TAG_MORE  = 5'b00010,
    PH_LEN_FIRST = 5'b00100,
    PH_LEN_MORE  = 5'b01000,
    PH_VALUE     = 5'b10000
  } phase_t;

  // Input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_buffer;
  } item_t;

  // Result beat.
  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  role;
    logic [3:0]  depth;
    logic        header_done;
    logic [31:0] tag_value;
    logic [15:0] value_length;
    logic        is_constructed;
    logic [3:0]  elements_closed;
    logic [2:0]  error_code;
  } result_t;

  // Commands from the parser to the end-position stack.
  typedef struct packed {
    logic               clear;
    logic               push;
    logic [LEVEL_W-1:0] pop_cnt;
    logic [POS_W-1:0]   push_end;
  } stk_ctrl_t;

  // Status from the end-position stack.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [POS_W-1:0]   top_end;
    logic [LEVEL_W-1:0] match_run;
  } stk_stat_t;

endpackage

/* src/btlv_stack.sv */
// ----------------------------------------------------------------------------
// BER-TLV end-position stack
// Holds the exclusive end positions of open constructed elements, reports
// the innermost end and how many stacked ends, counted from the top, equal
// a probe position, and applies push, multi-pop and clear commands.
// ----------------------------------------------------------------------------
module btlv_stack
  import btlv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [POS_W-1:0] probe_pos,
  input  stk_ctrl_t        ctrl,
  output stk_stat_t        stat
);

  logic [POS_W-1:0]   end_stack [MAX_DEPTH];
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] top_pos;
  logic [LEVEL_W-1:0] run_cnt;
  logic               run;

  // Innermost end: entries below the level are always written.
  assign top_pos = level - LEVEL_W'(1);

  // Count equal ends from the top down while the run holds.
  always_comb begin
    run     = 1'b1;
    run_cnt = '0;
    for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
      if (LEVEL_W'(i) < level) begin
        if (run && (end_stack[i] == probe_pos)) begin
          run_cnt = run_cnt + LEVEL_W'(1);
        end else begin
          run = 1'b0;
        end
      end
    end
  end

  always_comb begin
    stat.level     = level;
    stat.top_end   = (level == '0) ? '0 : end_stack[top_pos[IDX_W-1:0]];
    stat.match_run = run_cnt;
  end

  // Stack pointer.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      level <= '0;
    end else begin
      level <= level + LEVEL_W'(ctrl.push) - ctrl.pop_cnt;
    end
  end

  // Entry storage; no reset, entries are written before they are read.
  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear) begin
      end_stack[level[IDX_W-1:0]] <= ctrl.push_end;
    end
  end

endmodule

/* src/ber_tlv_stream_parser_core.sv */
// ----------------------------------------------------------------------------
// BER-TLV stream parser core
// Classifies a BER-TLV buffer byte by byte: role, depth, completed headers,
// closing elements and errors.
// ----------------------------------------------------------------------------
// Usage:
// One byte of the encoded buffer enters per beat on the item channel, with
// last_in_buffer marking the buffer's final byte. Each item beat yields
// exactly one result beat on the result channel, in order.
// Results are registered, valid in the cycle after the byte is accepted.
// Throughput is one byte per cycle unless the result channel stalls; the
// per-byte parse step, including the parallel compare against all stacked
// end positions, is one combinational pass from state to result register.
// The item channel stalls only while a result is held and the result
// channel stalls; the held result does not change during that time.
// After an error all bytes up to the marked last byte come out as discards.
// The marked last byte always returns the parser to its reset state.
// Reset is synchronous: it empties the result register and clears the
// parse state and the end-position stack pointer.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser_core
  import btlv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // Parse state.
  phase_t              phase, phase_next;
  logic [31:0]         tag_shift, tag_shift_next;
  logic [TCNT_W-1:0]   tag_count, tag_count_next;
  logic [LEFT_W-1:0]   length_left, length_left_next;
  logic [15:0]         length_accum, length_accum_next;
  logic [POS_W-1:0]    byte_position;
  logic [POS_W-1:0]    value_end, value_end_next;
  logic                first_constructed, first_constructed_next;
  logic                error_latched;

  // Step signals.
  logic                accept;
  logic [7:0]          b;
  logic                last;
  logic [POS_W-1:0]    pos_base;
  logic [POS_W-1:0]    nxt;
  logic [POS_W:0]      end_sum;
  logic [LEFT_W-1:0]   left_dec;
  logic [LEVEL_W-1:0]  level_next;
  logic [LEVEL_W-1:0]  pop_cnt;
  logic [CLOSE_W-1:0]  closed;
  logic [1:0]          role;
  logic [2:0]          err;
  logic                done;
  logic                hdr;
  logic                push;
  stk_ctrl_t           stk_ctrl;
  stk_stat_t           stk_stat;
  result_t             result_next;

  assign accept     = item_valid && !item_stall;
  assign item_stall = result_valid && result_stall;
  assign b          = item.data_byte;
  assign last       = item.last_in_buffer;

  // Position of this byte; it restarts at each top-level first tag byte.
  assign pos_base = ((phase == PH_TAG_FIRST) && (stk_stat.level == '0)) ? '0 : byte_position;
  assign nxt      = pos_base + POS_W'(1);
  assign left_dec = (length_left != '0) ? length_left - LEFT_W'(1) : '0;

  // One parse step for the incoming byte.
  always_comb begin
    phase_next             = phase;
    tag_shift_next         = tag_shift;
    tag_count_next         = tag_count;
    length_left_next       = length_left;
    length_accum_next      = length_accum;
    first_constructed_next = first_constructed;
    value_end_next         = value_end;
    role                   = ROLE_DISCARD;
    err                    = ERR_NONE;
    done                   = 1'b0;
    closed                 = '0;
    hdr                    = 1'b0;
    push                   = 1'b0;
    end_sum                = '0;

    case (phase)
      PH_TAG_FIRST: begin
        role                   = ROLE_TAG;
        tag_shift_next         = {24'd0, b};
        tag_count_next         = TCNT_W'(1);
        first_constructed_next = b[5];
        phase_next             = (b[4:0] == 5'h1F) ? PH_TAG_MORE : PH_LEN_FIRST;
      end
      PH_TAG_MORE: begin
        role = ROLE_TAG;
        if (tag_count >= TCNT_W'(TAG_BYTES)) begin
          err = ERR_TAG_LONG;
        end else begin
          tag_shift_next = {tag_shift[23:0], b};
          tag_count_next = tag_count + TCNT_W'(1);
          if (!b[7]) begin
            phase_next = PH_LEN_FIRST;
          end
        end
      end
      PH_LEN_FIRST: begin
        role = ROLE_LENGTH;
        if (b[7]) begin
          // Long form; the indefinite form has a zero count.
          if ((b[6:0] == 7'd0) || (b[6:0] > 7'(LENGTH_BYTES))) begin
            err = ERR_LEN_FORM;
          end else begin
            length_accum_next = '0;
            length_left_next  = LEFT_W'(b[6:0]);
            phase_next        = PH_LEN_MORE;
          end
        end else begin
          length_accum_next = {8'd0, b};
          done              = 1'b1;
        end
      end
      PH_LEN_MORE: begin
        role = ROLE_LENGTH;
        if (length_accum[15:8] != 8'd0) begin
          err = ERR_LEN_FORM;
        end else begin
          length_accum_next = {length_accum[7:0], b};
          length_left_next  = left_dec;
          if (left_dec == '0) begin
            done = 1'b1;
          end
        end
      end
      PH_VALUE: begin
        role = ROLE_VALUE;
        if (nxt == value_end) begin
          closed     = CLOSE_W'(1);
          phase_next = PH_TAG_FIRST;
        end
      end
      default: begin
        role = ROLE_TAG;
        err  = ERR_TAG_LONG;
      end
    endcase

    // A header byte must leave room inside the parent.
    if ((err == ERR_NONE) && ((role == ROLE_TAG) || (role == ROLE_LENGTH)) && !done &&
        (stk_stat.level != '0) && (nxt >= stk_stat.top_end)) begin
      err = ERR_OVERRUN;
    end

    // Completed header: place the element.
    if (done && (err == ERR_NONE)) begin
      end_sum = {1'b0, nxt} + (POS_W + 1)'(length_accum_next);
      if ((stk_stat.level != '0) && (end_sum > {1'b0, stk_stat.top_end})) begin
        err = ERR_OVERRUN;
      end else if (length_accum_next == 16'd0) begin
        closed     = CLOSE_W'(1);
        phase_next = PH_TAG_FIRST;
      end else if (first_constructed_next) begin
        if (stk_stat.level >= LEVEL_W'(MAX_DEPTH)) begin
          err = ERR_TOO_DEEP;
        end else begin
          push       = 1'b1;
          phase_next = PH_TAG_FIRST;
        end
      end else begin
        value_end_next = end_sum[POS_W-1:0];
        phase_next     = PH_VALUE;
      end
      if (err == ERR_NONE) begin
        hdr = 1'b1;
      end
    end

    // Enclosing elements that end on this same byte close with it.
    pop_cnt    = ((closed != '0) && (err == ERR_NONE)) ? stk_stat.match_run : '0;
    closed     = closed + CLOSE_W'(pop_cnt);
    level_next = stk_stat.level + LEVEL_W'(push) - pop_cnt;

    // The buffer must not end with an element still open.
    if (last && (err == ERR_NONE) &&
        ((phase_next != PH_TAG_FIRST) || (level_next != '0))) begin
      err = ERR_TRUNCATED;
    end
    if (err != ERR_NONE) begin
      hdr     = 1'b0;
      closed  = '0;
      push    = 1'b0;
      pop_cnt = '0;
    end
  end

  // Result beat for the incoming byte.
  always_comb begin
    result_next          = '0;
    result_next.byte_out = b;
    if (error_latched) begin
      result_next.role = ROLE_DISCARD;
    end else begin
      result_next.role            = role;
      result_next.depth           = 4'(stk_stat.level);
      result_next.header_done     = hdr;
      result_next.tag_value       = hdr ? tag_shift_next : '0;
      result_next.value_length    = hdr ? length_accum_next : '0;
      result_next.is_constructed  = hdr && first_constructed_next;
      result_next.elements_closed = 4'(closed);
      result_next.error_code      = err;
    end
  end

  // Stack commands, applied only for an accepted byte.
  always_comb begin
    stk_ctrl.clear    = accept && last;
    stk_ctrl.push     = accept && !error_latched && push;
    stk_ctrl.pop_cnt  = (accept && !error_latched) ? pop_cnt : '0;
    stk_ctrl.push_end = end_sum[POS_W-1:0];
  end

  btlv_stack u_stack (
    .clk       (clk),
    .rst       (rst),
    .probe_pos (nxt),
    .ctrl      (stk_ctrl),
    .stat      (stk_stat)
  );

  // Parse state update.
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      phase             <= PH_TAG_FIRST;
      tag_shift         <= '0;
      tag_count         <= '0;
      length_left       <= '0;
      length_accum      <= '0;
      byte_position     <= '0;
      value_end         <= '0;
      first_constructed <= 1'b0;
      error_latched     <= 1'b0;
    end else if (accept && !error_latched) begin
      if (err != ERR_NONE) begin
        error_latched <= 1'b1;
      end else begin
        phase             <= phase_next;
        tag_shift         <= tag_shift_next;
        tag_count         <= tag_count_next;
        length_left       <= length_left_next;
        length_accum      <= length_accum_next;
        byte_position     <= nxt;
        value_end         <= value_end_next;
        first_constructed <= first_constructed_next;
      end
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

/* tb/sv/btlv_classify_check.sv */
// ----------------------------------------------------------------------------
// BER-TLV parser result checker
// Watches the byte and result channels of the parser core. It keeps its own
// copy of the parse state and works out the classification of every accepted
// byte. Each result beat is compared field by field with the oldest
// classification still waiting. The failure count and the number of waiting
// classifications are passed to the testbench top.
// ----------------------------------------------------------------------------
module btlv_classify_check
  import btlv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      fail_count,
  output int      waiting_count
);

  // Parse state of the checker's own parser.
  phase_t       cur_phase;
  logic [31:0]  tag_word;
  int unsigned  tag_len;
  int unsigned  len_todo;
  logic [15:0]  len_word;
  logic [23:0]  offset;
  logic [23:0]  prim_end;
  logic [23:0]  end_marks [MAX_DEPTH];
  int unsigned  nest;
  bit           in_error;
  bit           first_is_cons;

  result_t      predicted_classes[$];
  int           mismatch_total = 0;

  // Back to the state that a new buffer starts from.
  function automatic void clear_parse_state();
    cur_phase     = PH_TAG_FIRST;
    tag_word      = '0;
    tag_len       = 0;
    len_todo      = 0;
    len_word      = '0;
    offset        = '0;
    prim_end      = '0;
    nest          = 0;
    in_error      = 1'b0;
    first_is_cons = 1'b0;
  endfunction

  // Classifies one byte and advances the parse state.
  function automatic result_t classify_byte(input item_t it);
    result_t     r;
    logic [7:0]  b;
    logic [1:0]  role;
    logic [2:0]  err;
    int unsigned closed;
    logic [23:0] nxt;
    logic [23:0] parent_end;
    logic [31:0] span_end;
    bit          done;
    bit          hdr;
    r = '0;
    b = it.data_byte;
    r.byte_out = b;

    // After an error every byte up to the end of the buffer is discarded.
    if (in_error) begin
      r.role = ROLE_DISCARD;
      if (it.last_in_buffer) clear_parse_state();
      return r;
    end

    // Positions count from each top-level first tag byte.
    if (cur_phase == PH_TAG_FIRST && nest == 0) offset = '0;
    nxt = offset + 24'd1;
    parent_end = (nest > 0) ? end_marks[nest - 1] : '0;
    r.depth = 4'(nest);
    err = ERR_NONE;
    closed = 0;
    done = 1'b0;
    hdr = 1'b0;
    role = ROLE_DISCARD;

    case (cur_phase)
      PH_TAG_FIRST: begin
        role = ROLE_TAG;
        tag_word = {24'd0, b};
        tag_len = 1;
        first_is_cons = b[5];
        cur_phase = (b[4:0] == 5'h1F) ? PH_TAG_MORE : PH_LEN_FIRST;
      end
      PH_TAG_MORE: begin
        role = ROLE_TAG;
        if (tag_len >= TAG_BYTES) begin
          err = ERR_TAG_LONG;
        end else begin
          tag_word = {tag_word[23:0], b};
          tag_len++;
          if (!b[7]) cur_phase = PH_LEN_FIRST;
        end
      end
      PH_LEN_FIRST: begin
        role = ROLE_LENGTH;
        if (b[7]) begin
          if (b[6:0] == 7'd0 || b[6:0] > LENGTH_BYTES) begin
            err = ERR_LEN_FORM;
          end else begin
            len_word = '0;
            len_todo = 32'(b[6:0]);
            cur_phase = PH_LEN_MORE;
          end
        end else begin
          len_word = {8'd0, b};
          done = 1'b1;
        end
      end
      PH_LEN_MORE: begin
        role = ROLE_LENGTH;
        if (len_word > 16'h00FF) begin
          err = ERR_LEN_FORM;
        end else begin
          len_word = {len_word[7:0], b};
          if (len_todo > 0) len_todo--;
          if (len_todo == 0) done = 1'b1;
        end
      end
      default: begin
        role = ROLE_VALUE;
        if (nxt == prim_end) begin
          closed = 1;
          cur_phase = PH_TAG_FIRST;
        end
      end
    endcase

    // A header byte must still leave room inside the parent.
    if (err == ERR_NONE && role != ROLE_VALUE && !done && nest > 0 && nxt >= parent_end)
      err = ERR_OVERRUN;

    // A finished header opens a value, a nested level, or closes at once.
    if (done && err == ERR_NONE) begin
      span_end = {8'd0, nxt} + {16'd0, len_word};
      if (nest > 0 && span_end > {8'd0, parent_end}) begin
        err = ERR_OVERRUN;
      end else if (len_word == 16'd0) begin
        closed = 1;
        cur_phase = PH_TAG_FIRST;
      end else if (first_is_cons) begin
        if (nest >= MAX_DEPTH) begin
          err = ERR_TOO_DEEP;
        end else begin
          end_marks[nest] = span_end[23:0];
          nest++;
          cur_phase = PH_TAG_FIRST;
        end
      end else begin
        prim_end = span_end[23:0];
        cur_phase = PH_VALUE;
      end
      if (err == ERR_NONE) hdr = 1'b1;
    end

    // Enclosing elements that end on the same byte close with it.
    if (closed != 0 && err == ERR_NONE) begin
      while (nest > 0 && end_marks[nest - 1] == nxt) begin
        nest--;
        closed++;
      end
    end
    offset = nxt;

    if (it.last_in_buffer && err == ERR_NONE && (cur_phase != PH_TAG_FIRST || nest != 0))
      err = ERR_TRUNCATED;
    if (err != ERR_NONE) begin
      in_error = 1'b1;
      hdr = 1'b0;
      closed = 0;
    end

    r.role = role;
    r.header_done = hdr;
    if (hdr) begin
      r.tag_value = tag_word;
      r.value_length = len_word;
      r.is_constructed = first_is_cons;
    end
    r.elements_closed = 4'(closed);
    r.error_code = err;
    if (it.last_in_buffer) clear_parse_state();
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_total++;
    end
  endfunction

  // Results are matched before the new byte is queued: as the core registers
  // its result, a result never belongs to the byte accepted at the same edge.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_parse_state();
      predicted_classes.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_classes.size() == 0) begin
          $error("result beat with no byte waiting: byte_out 0x%0h", result.byte_out);
          mismatch_total++;
        end else begin
          want = predicted_classes.pop_front();
          check_field("byte_out", 32'(want.byte_out), 32'(result.byte_out));
          check_field("role", 32'(want.role), 32'(result.role));
          check_field("depth", 32'(want.depth), 32'(result.depth));
          check_field("header_done", 32'(want.header_done), 32'(result.header_done));
          check_field("tag_value", want.tag_value, result.tag_value);
          check_field("value_length", 32'(want.value_length), 32'(result.value_length));
          check_field("is_constructed", 32'(want.is_constructed),
                      32'(result.is_constructed));
          check_field("elements_closed", 32'(want.elements_closed),
                      32'(result.elements_closed));
          check_field("error_code", 32'(want.error_code), 32'(result.error_code));
        end
      end
      if (item_valid && !item_stall) predicted_classes.push_back(classify_byte(item));
    end
    fail_count <= mismatch_total;
    waiting_count <= predicted_classes.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// BER-TLV parser testbench top
// Feeds the parser core with buffers: a few hand-built ones that reach each
// error but the depth one and a three-element closing, then random buffers
// that are mostly well formed, some nested to the depth limit, some cut
// short, corrupted or pure noise. Both channels idle at random. The checker
// beside the core does the comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import btlv_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  localparam int QUIET_LIMIT = 2000;
  localparam int SEND_BYTES  = 1950;

  logic    clk;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  item_t   item = '0;
  logic    item_stall;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  int      fail_count;
  int      waiting_count;
  int      idle_pct = 17;
  int      quiet_cycles = 0;

  ber_tlv_stream_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  btlv_classify_check chk (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .fail_count    (fail_count),
    .waiting_count (waiting_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    result_stall <= (idle_pct != 0) && ($urandom_range(0, 99) < idle_pct);
  end

  // Watchdog: too many cycles without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Random element: tag, length and contents, nested up to max_lvl.
  // With chain set every level below max_lvl is constructed with one child.
  function automatic octet_q_t make_elem(input int lvl, input int max_lvl, input bit chain);
    octet_q_t    elem;
    octet_q_t    body;
    logic [7:0]  b;
    bit          cons;
    int          kids;
    int          extra;
    int          form;
    int unsigned n;
    cons = (lvl < max_lvl) && (chain || $urandom_range(0, 2) != 0);

    // Contents come first so that the length is known.
    if (cons) begin
      if (chain) kids = 1;
      else kids = (lvl < 2) ? $urandom_range(0, 3) : $urandom_range(0, 1);
      for (int i = 0; i < kids; i++) body = {body, make_elem(lvl + 1, max_lvl, chain)};
    end else begin
      n = ($urandom_range(0, 24) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 10);
      repeat (n) body.push_back(8'($urandom));
    end

    // Tag: a single byte, or a 0x1F lead with continuation bytes, now and
    // then one byte more than the parser takes.
    b = 8'($urandom);
    b[5] = cons;
    if ($urandom_range(0, 3) == 0) begin
      b[4:0] = 5'h1F;
      elem.push_back(b);
      extra = ($urandom_range(0, 15) == 0) ? TAG_BYTES : $urandom_range(1, TAG_BYTES - 1);
      for (int i = 0; i < extra; i++) begin
        b = 8'($urandom);
        b[7] = (i != extra - 1);
        elem.push_back(b);
      end
    end else begin
      if (b[4:0] == 5'h1F) b[0] = 1'b0;
      elem.push_back(b);
    end

    // Length in short form or with one or two length bytes.
    n = body.size();
    form = $urandom_range(0, 3);
    if (n < 128 && form < 2) elem.push_back(8'(n));
    else if (n < 256 && form != 3) elem = {elem, 8'h81, 8'(n)};
    else elem = {elem, 8'h82, 8'(n >> 8), 8'(n)};
    elem = {elem, body};
    return elem;
  endfunction

  function automatic octet_q_t make_buffer(input int max_lvl, input bit chain);
    octet_q_t frame;
    int       tops;
    tops = $urandom_range(1, 2);
    repeat (tops) frame = {frame, make_elem(0, max_lvl, chain)};
    return frame;
  endfunction

  // Sends one buffer, one byte per beat, the final byte marked last.
  task automatic send_buffer(input octet_q_t bytes);
    for (int i = 0; i < bytes.size(); i++) begin
      while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
      item_valid <= 1'b1;
      item <= '{data_byte: bytes[i], last_in_buffer: (i == bytes.size() - 1)};
      @(posedge clk);
      while (item_stall) @(posedge clk);
    end
  endtask

  // Holds the byte channel idle until every result has come back.
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (waiting_count != 0);
  endtask

  initial begin
    octet_q_t frame;
    int       sent_bytes;
    int       pick;
    int       cut;
    bit       paused;
    sent_bytes = 0;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Three nested elements with a multi-byte tag all close on the 0xFF.
    frame = {8'h3F, 8'h81, 8'h01, 8'h81, 8'h05, 8'h21, 8'h03, 8'h02, 8'h01, 8'hFF};
    send_buffer(frame);
    // Zero length in two-byte long form.
    frame = {8'h05, 8'h82, 8'h00, 8'h00};
    send_buffer(frame);
    // Tag one byte longer than allowed.
    frame = {8'h1F, 8'h81, 8'h81, 8'h81, 8'h81};
    send_buffer(frame);
    // Indefinite length form.
    frame = {8'h04, 8'h80};
    send_buffer(frame);
    // Child header that cannot fit in its parent, then a discarded byte.
    frame = {8'h21, 8'h01, 8'h04, 8'hFF};
    send_buffer(frame);
    // Buffer that ends inside a header.
    frame = {8'h00};
    send_buffer(frame);
    drain();

    // Random buffers: mostly well formed, some chained to the depth limit,
    // the rest broken or noise. A calm stretch runs without any idling.
    while (sent_bytes < SEND_BYTES) begin
      idle_pct <= (sent_bytes >= 700 && sent_bytes < 1000) ? 0 : 17;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        frame = make_buffer($urandom_range(1, 4), 1'b0);
      end else if (pick < 80) begin
        frame = make_buffer($urandom_range(7, 9), 1'b1);
      end else begin
        frame = make_buffer($urandom_range(1, 4), 1'b0);
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          cut = $urandom_range(1, frame.size());
          while (frame.size() > cut) void'(frame.pop_back());
        end else if (pick == 1) begin
          frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
        end else begin
          frame.delete();
          repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom));
        end
      end
      send_buffer(frame);
      sent_bytes += frame.size();
      if (!paused && sent_bytes >= 1200) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
src/btlv_pkg.sv
src/btlv_stack.sv
src/ber_tlv_stream_parser_core.sv
tb/sv/btlv_classify_check.sv
tb/sv/tb_top.sv
